/* design/meg_pkg.sv */
// Shared types, constants and the glyph gradient for the escape-time glyph block.
`timescale 1ns / 1ps

package meg_pkg;

    localparam int FRACTION_BITS = 60;
    localparam int LIMIT_CEILING = 100000;

    localparam int COORD_W   = 64;
    localparam int COUNT_W   = 17;
    localparam int GLYPH_W   = 8;
    localparam int PAIR_W    = 2;
    localparam int HALF_W    = COORD_W / 2;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int MID_W     = COORD_W + 1;
    localparam int NPROD     = 3;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(100);

    localparam int GLYPH_SPAN = 22;
    localparam int QUOT_W     = 5;
    localparam int DIV_W      = COUNT_W + QUOT_W;
    localparam int DSTEP_W    = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [COORD_W-1:0] FIXED_TWO  = COORD_W'(1) << (FRACTION_BITS + 1);
    localparam logic [COORD_W-1:0] FIXED_FOUR = COORD_W'(1) << (FRACTION_BITS + 2);
    localparam logic [COORD_W-1:0] SIGN_MIN   = COORD_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] SIGN_MAX   = ~SIGN_MIN;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_real;
        logic signed [COORD_W-1:0] point_imag;
    } t_point_item;

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic [GLYPH_W-1:0] glyph_code;
        logic [PAIR_W-1:0]  tint_index;
        logic               bold_flag;
    } t_result_item;

    typedef struct packed {
        t_point_item        point;
        logic [COUNT_W-1:0] limit;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [QUOT_W-1:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            5'd0:    g = " ";
            5'd1:    g = ".";
            5'd2:    g = ",";
            5'd3:    g = ":";
            5'd4:    g = ";";
            5'd5:    g = "i";
            5'd6:    g = "r";
            5'd7:    g = "s";
            5'd8:    g = "X";
            5'd9:    g = "A";
            5'd10:   g = "2";
            5'd11:   g = "5";
            5'd12:   g = "3";
            5'd13:   g = "h";
            5'd14:   g = "M";
            5'd15:   g = "H";
            5'd16:   g = "G";
            5'd17:   g = "S";
            5'd18:   g = "#";
            5'd19:   g = "9";
            5'd20:   g = "B";
            5'd21:   g = "&";
            default: g = "@";
        endcase
        return g;
    endfunction

endpackage

/* design/meg_front.sv */
// Front end: iteration limit register, input acceptance and limit clamping.
`timescale 1ns / 1ps

module meg_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  meg_pkg::t_point_item         i_point,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [meg_pkg::COUNT_W-1:0]  i_cfg_data,
    input  meg_pkg::t_queue_status       i_status,
    output meg_pkg::t_push               o_push
);
    import meg_pkg::*;

    logic [COUNT_W-1:0] r_limit;
    logic [COUNT_W-1:0] n_limit;
    logic [COUNT_W-1:0] eff_limit;

    assign o_cfg_ready = 1'b1;
    assign busy        = i_status.full;

    always_comb begin
        n_limit = r_limit;
        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = i_cfg_data;
        end
    end

    always_comb begin
        if (32'(r_limit) > 32'(LIMIT_CEILING)) begin
            eff_limit = COUNT_W'(LIMIT_CEILING);
        end else begin
            eff_limit = r_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else begin
            r_limit <= n_limit;
        end
    end

    assign o_push.valid       = start && !busy;
    assign o_push.job.point   = i_point;
    assign o_push.job.limit   = eff_limit;

endmodule

/* design/meg_fifo.sv */
// Short job queue between the front end and the iteration core.
`timescale 1ns / 1ps

module meg_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  meg_pkg::t_push         i_push,
    input  logic                   i_pop,
    output meg_pkg::t_queue_status o_status,
    output meg_pkg::t_job          o_head
);
    import meg_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_fill;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_fill == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

/* design/meg_core.sv */
// Iteration core: escape loop over split products, glyph divider and result register.
`timescale 1ns / 1ps

module meg_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  meg_pkg::t_queue_status i_status,
    input  meg_pkg::t_job          i_head,
    output logic                   o_pop,
    output logic                   o_done,
    output meg_pkg::t_result_item  o_result
);
    import meg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MAG  = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_MID  = 8'b0000_1000,
        S_PROD = 8'b0001_0000,
        S_UPD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic               r_done, n_done;
    t_result_item       r_result, n_result;
    logic [COORD_W-1:0] r_cr, n_cr;
    logic [COORD_W-1:0] r_ci, n_ci;
    logic [COUNT_W-1:0] r_limit, n_limit;
    logic [COORD_W-1:0] r_zr, n_zr;
    logic [COORD_W-1:0] r_zi, n_zi;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PAIR_W-1:0]  r_band, n_band;
    logic [COORD_W-1:0] r_mr, n_mr;
    logic [COORD_W-1:0] r_mi, n_mi;
    logic               r_neg, n_neg;
    logic [COORD_W-1:0] r_p00 [NPROD], n_p00 [NPROD];
    logic [COORD_W-1:0] r_p01 [NPROD], n_p01 [NPROD];
    logic [COORD_W-1:0] r_p10 [NPROD], n_p10 [NPROD];
    logic [COORD_W-1:0] r_p11 [NPROD], n_p11 [NPROD];
    logic [MID_W-1:0]   r_mid [NPROD], n_mid [NPROD];
    logic [COORD_W-1:0] r_prod [NPROD], n_prod [NPROD];
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [QUOT_W-1:0]  r_quot, n_quot;
    logic [DSTEP_W-1:0] r_dstep, n_dstep;

    logic [COORD_W-1:0] op_a [NPROD];
    logic [COORD_W-1:0] op_b [NPROD];
    logic [COORD_W-1:0] mag_r, mag_i;
    logic [MID_W-1:0]   sq_sum;
    logic [COORD_W-1:0] cross_mag;
    logic               cross_neg;
    logic [PROD_W-1:0]  full [NPROD];
    logic [DIV_W-1:0]   dividend;
    logic [DIV_W-1:0]   div_shift;
    logic               escaped;

    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] s;
        s = a + b;
        if ((a[COORD_W-1] == b[COORD_W-1]) && (s[COORD_W-1] != a[COORD_W-1])) begin
            s = a[COORD_W-1] ? SIGN_MIN : SIGN_MAX;
        end
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] from_sign_mag(input logic neg,
                                                         input logic [COORD_W-1:0] mag);
        logic [COORD_W-1:0] v;
        if (neg) begin
            v = '0 - mag;
        end else begin
            v = mag[COORD_W-1] ? SIGN_MAX : mag;
        end
        return v;
    endfunction

    assign mag_r = r_zr[COORD_W-1] ? ('0 - r_zr) : r_zr;
    assign mag_i = r_zi[COORD_W-1] ? ('0 - r_zi) : r_zi;

    assign op_a[0] = r_mr;
    assign op_b[0] = r_mr;
    assign op_a[1] = r_mi;
    assign op_b[1] = r_mi;
    assign op_a[2] = r_mr;
    assign op_b[2] = r_mi;

    always_comb begin
        for (int k = 0; k < NPROD; k++) begin
            full[k] = {r_p11[k], r_p00[k]} + (PROD_W'(r_mid[k]) << HALF_W);
        end
    end

    assign sq_sum    = MID_W'(r_prod[0]) + MID_W'(r_prod[1]);
    assign cross_mag = r_prod[2] << 1;
    assign cross_neg = r_neg && (cross_mag != '0);
    assign dividend  = DIV_W'(r_count) * DIV_W'(GLYPH_SPAN);
    assign div_shift = DIV_W'(r_limit) << r_dstep;
    assign escaped   = r_count < r_limit;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_limit  = r_limit;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_count  = r_count;
        n_band   = r_band;
        n_mr     = r_mr;
        n_mi     = r_mi;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_dstep  = r_dstep;
        o_pop    = 1'b0;
        for (int k = 0; k < NPROD; k++) begin
            n_p00[k]  = r_p00[k];
            n_p01[k]  = r_p01[k];
            n_p10[k]  = r_p10[k];
            n_p11[k]  = r_p11[k];
            n_mid[k]  = r_mid[k];
            n_prod[k] = r_prod[k];
        end

        case (r_state)
            S_IDLE: begin
                if (!i_status.empty) begin
                    o_pop   = 1'b1;
                    n_cr    = i_head.point.point_real;
                    n_ci    = i_head.point.point_imag;
                    n_limit = i_head.limit;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_count = '0;
                    n_band  = '0;
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_mr    = mag_r;
                n_mi    = mag_i;
                n_neg   = r_zr[COORD_W-1] ^ r_zi[COORD_W-1];
                n_rem   = dividend;
                n_quot  = '0;
                n_dstep = DSTEP_W'(QUOT_W - 1);
                if (!escaped) begin
                    n_state = S_OUT;
                end else if ((mag_r > FIXED_TWO) || (mag_i > FIXED_TWO)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                for (int k = 0; k < NPROD; k++) begin
                    n_p00[k] = op_a[k][HALF_W-1:0] * op_b[k][HALF_W-1:0];
                    n_p01[k] = op_a[k][HALF_W-1:0] * op_b[k][COORD_W-1:HALF_W];
                    n_p10[k] = op_a[k][COORD_W-1:HALF_W] * op_b[k][HALF_W-1:0];
                    n_p11[k] = op_a[k][COORD_W-1:HALF_W] * op_b[k][COORD_W-1:HALF_W];
                end
                n_state = S_MID;
            end
            S_MID: begin
                for (int k = 0; k < NPROD; k++) begin
                    n_mid[k] = MID_W'(r_p01[k]) + MID_W'(r_p10[k]);
                end
                n_state = S_PROD;
            end
            S_PROD: begin
                for (int k = 0; k < NPROD; k++) begin
                    n_prod[k] = full[k][FRACTION_BITS +: COORD_W];
                end
                n_state = S_UPD;
            end
            S_UPD: begin
                if (sq_sum > MID_W'(FIXED_FOUR)) begin
                    n_state = S_DIV;
                end else begin
                    n_zi    = sat_add(from_sign_mag(cross_neg, cross_mag), r_ci);
                    n_zr    = sat_add(r_prod[0] - r_prod[1], r_cr);
                    n_count = r_count + 1'b1;
                    if (r_count[2:0] == 3'b111) begin
                        n_band = (r_band == PAIR_W'(2)) ? '0 : r_band + 1'b1;
                    end
                    n_state = S_MAG;
                end
            end
            S_DIV: begin
                if (r_rem >= div_shift) begin
                    n_rem           = r_rem - div_shift;
                    n_quot[r_dstep] = 1'b1;
                end
                if (r_dstep == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_dstep = r_dstep - 1'b1;
                end
            end
            S_OUT: begin
                n_done                = 1'b1;
                n_result.escape_count = r_count;
                n_result.glyph_code   = escaped ? glyph_of(r_quot) : GLYPH_SPACE;
                n_result.tint_index   = escaped ? r_band + 1'b1 : '0;
                n_result.bold_flag    = escaped;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_cr     <= n_cr;
        r_ci     <= n_ci;
        r_limit  <= n_limit;
        r_zr     <= n_zr;
        r_zi     <= n_zi;
        r_count  <= n_count;
        r_band   <= n_band;
        r_mr     <= n_mr;
        r_mi     <= n_mi;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_dstep  <= n_dstep;
        for (int k = 0; k < NPROD; k++) begin
            r_p00[k]  <= n_p00[k];
            r_p01[k]  <= n_p01[k];
            r_p10[k]  <= n_p10[k];
            r_p11[k]  <= n_p11[k];
            r_mid[k]  <= n_mid[k];
            r_prod[k] <= n_prod[k];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* design/mandelbrot_escape_glyph.sv */
// Top level of the escape-time glyph block: front end, job queue and iteration core.
`timescale 1ns / 1ps

// A point is taken whenever start is high and busy is low; busy rises only when
// the two-entry job queue is full. The core runs each escape iteration as a
// sequence of states (magnitude check, split 32-bit partial products, middle
// sum, product assembly, escape test and orbit update). A point stops when it
// reaches the limit, when a coordinate magnitude exceeds two or when the sum
// of squares exceeds four; the last two pass through glyph division, and
// o_done is registered from the output state that follows. Each result
// appears on o_result with o_done high for exactly one cycle and must be
// captured then, since the block has no way to hold a result back. The
// iteration limit may be written through the configuration channel, which is
// always ready, only while no point is in flight.

module mandelbrot_escape_glyph (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  meg_pkg::t_point_item         i_point,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [meg_pkg::COUNT_W-1:0]  i_cfg_data,
    output logic                         o_done,
    output meg_pkg::t_result_item        o_result
);
    import meg_pkg::*;

    t_push         push;
    t_queue_status status;
    t_job          head;
    logic          pop;

    meg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_push      (push)
    );

    meg_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (status),
        .o_head   (head)
    );

    meg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .i_head   (head),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
